// ===== sv/hddi_pkg.sv =====
// ----------------------------------------------------------------------------
// hddi_pkg: shared types, constants and arithmetic helpers
// Constants, item types, state codes and fixed-point helpers for the Hermite
// divided-difference interpolator.
// ----------------------------------------------------------------------------
package hddi_pkg;

   localparam int DATA_W      = 32;
   localparam int FRAC_BITS   = 16;
   localparam int NODE_COUNT  = 3;
   localparam int REPEAT      = 3;
   localparam int ENTRY_COUNT = REPEAT * NODE_COUNT;
   localparam int NODE_W      = $clog2(NODE_COUNT);
   localparam int PHASE_W     = $clog2(REPEAT);
   localparam int ENTRY_W     = $clog2(ENTRY_COUNT);
   localparam int COL_W       = $clog2(ENTRY_COUNT + 1);
   localparam int DEN_W       = DATA_W + 1;
   localparam int DVD_W       = DATA_W + FRAC_BITS;
   localparam int CNT_W       = $clog2(DVD_W + 1);
   localparam int PROD_W      = 2 * DATA_W;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EVAL = 1'b1;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_COINCIDENT = 2'd1;
   localparam logic [1:0] STATUS_NOT_BUILT  = 2'd2;
   localparam logic [1:0] STATUS_SATURATED  = 2'd3;

   localparam logic [NODE_COUNT-1:0] FULL_MASK = {NODE_COUNT{1'b1}};

   typedef struct packed {
      logic               operation;
      logic [1:0]         node_index;
      logic signed [31:0] node_x;
      logic signed [31:0] node_value;
      logic signed [31:0] node_slope;
      logic signed [31:0] node_curvature;
      logic signed [31:0] query_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_COL,
      ST_READ,
      ST_SUB,
      ST_DIV,
      ST_WRITE,
      ST_MUL_C,
      ST_TERM,
      ST_ACC,
      ST_DIFF,
      ST_MUL_D,
      ST_SCALE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic                     sat;
   } sat_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quo;
      logic                     sat;
   } div_res_type;

   function automatic logic [NODE_W-1:0] node_of(input logic [ENTRY_W-1:0] e);
      logic [NODE_W-1:0] n;
      n = '0;
      for (int k = 1; k < NODE_COUNT; k++) begin
         if (32'(e) >= k * REPEAT) begin
            n = NODE_W'(k);
         end
      end
      return n;
   endfunction

   function automatic logic [PHASE_W-1:0] phase_of(input logic [ENTRY_W-1:0] e);
      return PHASE_W'(32'(e) - REPEAT * 32'(node_of(e)));
   endfunction

   function automatic sat_type sat_wide(input logic signed [DATA_W:0] v);
      sat_type r;
      r.sat = v[DATA_W] ^ v[DATA_W-1];
      if (!r.sat) begin
         r.val = v[DATA_W-1:0];
      end else if (v[DATA_W]) begin
         r.val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.val = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic sat_type qscale(input logic signed [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] q;
      sat_type r;
      q = p >>> FRAC_BITS;
      if (p[PROD_W-1] && (|p[FRAC_BITS-1:0])) begin
         q = q + PROD_W'(1);
      end
      r.sat = (q[PROD_W-1:DATA_W-1] != {(PROD_W-DATA_W+1){q[PROD_W-1]}});
      if (!r.sat) begin
         r.val = q[DATA_W-1:0];
      end else if (q[PROD_W-1]) begin
         r.val = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r.val = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic logic signed [DATA_W-1:0] half_toward_zero(
      input logic signed [DATA_W-1:0] c);
      logic signed [DATA_W:0] t;
      t = (DATA_W+1)'(c) + $signed({{DATA_W{1'b0}}, c[DATA_W-1]});
      return t[DATA_W:1];
   endfunction

endpackage

// ===== sv/hddi_if.sv =====
// ----------------------------------------------------------------------------
// hddi_if: item channels
// Valid/ready channels that carry request and response items.
// ----------------------------------------------------------------------------
interface hddi_req_if import hddi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface hddi_rsp_if import hddi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/hddi_div.sv =====
// ----------------------------------------------------------------------------
// hddi_div: iterative fixed-point divider
// Computes (num * 2^FRAC_BITS) / den truncated toward zero and saturated,
// one quotient bit per cycle with a restoring step.
// ----------------------------------------------------------------------------
module hddi_div import hddi_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] num,
   input  logic signed [DEN_W-1:0]  den,
   output div_res_type              res
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DEN_W-1:0]  dvs_ff, dvs_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0] num_mag;
   logic [DEN_W-1:0]  den_mag;
   logic [DEN_W:0]    rem_shift;

   always_comb begin
      num_mag   = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
      den_mag   = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      rem_shift = {rem_ff, dvd_ff[DVD_W-1]};
      run_in    = run_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DVD_W);
         neg_in = num[DATA_W-1] ^ den[DEN_W-1];
         dvd_in = {num_mag, {FRAC_BITS{1'b0}}};
         dvs_in = den_mag;
         rem_in = '0;
      end else if (run_ff) begin
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in = DEN_W'(rem_shift - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = DEN_W'(rem_shift);
            dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   always_comb begin
      res.done = done_ff;
      if (!neg_ff) begin
         res.sat = |dvd_ff[DVD_W-1:DATA_W-1];
         res.quo = res.sat ? {1'b0, {(DATA_W-1){1'b1}}} : dvd_ff[DATA_W-1:0];
      end else begin
         res.sat = (|dvd_ff[DVD_W-1:DATA_W])
                   || (dvd_ff[DATA_W-1] && (|dvd_ff[DATA_W-2:0]));
         res.quo = res.sat ? {1'b1, {(DATA_W-1){1'b0}}}
                           : DATA_W'(-dvd_ff[DATA_W-1:0]);
      end
   end

endmodule

// ===== sv/hermite_divided_difference_interp.sv =====
// ----------------------------------------------------------------------------
// hermite_divided_difference_interp: Hermite interpolator, Newton form
// Stores three nodes with value, slope and curvature, builds the confluent
// divided-difference table after the last load and evaluates the Newton
// polynomial at a query point in signed Q16.16.
//
//   channel  role    items
//   req_ch   sink    load node / evaluate at query point
//   rsp_ch   source  one result per evaluate, none per load
//
// A load is stored from the idle state. The load that completes the node
// set starts a table build paced by the serial divider, which runs once for
// each of the 27 table entries that need a division. An evaluate computes
// its result through the shared multiplier. A result held back on rsp_ch
// stalls the next evaluate in its done state, and the input with it, until
// the held result is taken. Synchronous reset clears the control state; the
// node stores are undefined until loaded.
// ----------------------------------------------------------------------------
module hermite_divided_difference_interp import hddi_pkg::*; (
   input logic        clock,
   input logic        reset,
   hddi_req_if.sink   req_ch,
   hddi_rsp_if.source rsp_ch
);

   state_type state_ff, state_in;

   logic signed [DATA_W-1:0] abs_ff [NODE_COUNT];
   logic signed [DATA_W-1:0] abs_in [NODE_COUNT];
   logic signed [DATA_W-1:0] nd_ff [ENTRY_COUNT];
   logic signed [DATA_W-1:0] nd_in [ENTRY_COUNT];
   logic signed [DATA_W-1:0] col_ff [ENTRY_COUNT];
   logic signed [DATA_W-1:0] col_in [ENTRY_COUNT];

   logic [NODE_COUNT-1:0]    mask_ff, mask_in;
   logic                     built_ff, built_in;
   logic                     err_ff, err_in;
   logic                     tsat_ff, tsat_in;
   logic                     bsat_ff, bsat_in;
   logic                     esat_ff, esat_in;
   logic [COL_W-1:0]         i_ff, i_in;
   logic [ENTRY_W-1:0]       j_ff, j_in;
   logic signed [DATA_W-1:0] prev_ff, prev_in;
   logic signed [DATA_W-1:0] old_ff, old_in;
   logic signed [DATA_W-1:0] xa_ff, xa_in;
   logic signed [DATA_W-1:0] new_ff, new_in;
   logic signed [DATA_W-1:0] point_ff, point_in;
   logic signed [DATA_W-1:0] k_ff, k_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic signed [DATA_W-1:0] term_ff, term_in;
   logic signed [DATA_W-1:0] d_ff, d_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [1:0]               stat_ff, stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     req_acc;
   logic                     load_ok;
   logic [NODE_W-1:0]        load_node;
   logic [NODE_COUNT-1:0]    mask_next;
   logic                     rsp_free;
   logic [ENTRY_W-1:0]       col_addr;
   logic signed [DATA_W-1:0] col_rd;
   logic [NODE_W-1:0]        abs_addr;
   logic signed [DATA_W-1:0] abs_rd;
   logic [ENTRY_W-1:0]       nd_addr;
   logic signed [DATA_W-1:0] nd_rd;
   logic signed [DATA_W-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [ENTRY_W-1:0]       lag_idx;
   logic                     take_slope;
   logic                     take_half;
   logic signed [DEN_W-1:0]  den;
   sat_type                  diff;
   sat_type                  scaled;
   logic                     div_start;
   div_res_type              div_res;

   hddi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (diff.val),
      .den   (den),
      .res   (div_res)
   );

   assign req_acc   = req_ch.valid && req_ch.ready;
   assign load_ok   = 32'(req_ch.payload.node_index) < NODE_COUNT;
   assign load_node = NODE_W'(req_ch.payload.node_index);
   assign mask_next = mask_ff | (NODE_COUNT'(1) << load_node);
   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign lag_idx   = ENTRY_W'(32'(j_ff) - 32'(i_ff) + 1);

   always_comb begin
      col_addr = j_ff;
      if (state_ff == ST_COL) begin
         col_addr = ENTRY_W'(i_ff - COL_W'(2));
      end
      abs_addr = node_of(j_ff);
      if (state_ff == ST_SUB) begin
         abs_addr = node_of(lag_idx);
      end
      nd_addr = ENTRY_W'(REPEAT * 32'(node_of(j_ff)) + ((i_ff == COL_W'(2)) ? 1 : 2));
      col_rd  = col_ff[col_addr];
      abs_rd  = abs_ff[abs_addr];
      nd_rd   = nd_ff[nd_addr];
      mul_b   = (state_ff == ST_MUL_D) ? d_ff : col_rd;
      mul_p   = k_ff * mul_b;
      scaled  = qscale(prod_ff);
      take_slope = (i_ff == COL_W'(2)) && (phase_of(j_ff) != PHASE_W'(0));
      take_half  = (i_ff == COL_W'(3)) && (phase_of(j_ff) == PHASE_W'(2));
      if (state_ff == ST_ACC) begin
         diff = sat_wide((DATA_W+1)'(res_ff) + (DATA_W+1)'(term_ff));
      end else if (state_ff == ST_DIFF) begin
         diff = sat_wide((DATA_W+1)'(point_ff) - (DATA_W+1)'(abs_rd));
      end else begin
         diff = sat_wide((DATA_W+1)'(old_ff) - (DATA_W+1)'(prev_ff));
      end
      den       = DEN_W'(xa_ff) - DEN_W'(abs_rd);
      div_start = (state_ff == ST_SUB) && (den != '0);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.payload.operation == OP_EVAL) begin
                  state_in = (built_ff && !err_ff) ? ST_MUL_C : ST_DONE;
               end else if (load_ok && mask_next == FULL_MASK) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT:  state_in = ST_READ;
         ST_COL:   state_in = ST_READ;
         ST_READ:  state_in = (take_slope || take_half) ? ST_WRITE : ST_SUB;
         ST_SUB:   state_in = (den == '0) ? ST_WRITE : ST_DIV;
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (32'(j_ff) == ENTRY_COUNT - 1) begin
               state_in = (32'(i_ff) == ENTRY_COUNT) ? ST_IDLE : ST_COL;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_MUL_C: state_in = ST_TERM;
         ST_TERM:  state_in = ST_ACC;
         ST_ACC:   state_in = (32'(j_ff) == ENTRY_COUNT - 1) ? ST_DONE : ST_DIFF;
         ST_DIFF:  state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_MUL_C;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready   = (state_ff == ST_IDLE);
      rsp_ch.valid   = rsp_valid_ff;
      rsp_ch.payload = rsp_ff;
   end

   always_comb begin
      abs_in       = abs_ff;
      nd_in        = nd_ff;
      col_in       = col_ff;
      mask_in      = mask_ff;
      built_in     = built_ff;
      err_in       = err_ff;
      tsat_in      = tsat_ff;
      bsat_in      = bsat_ff;
      esat_in      = esat_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      prev_in      = prev_ff;
      old_in       = old_ff;
      xa_in        = xa_ff;
      new_in       = new_ff;
      point_in     = point_ff;
      k_in         = k_ff;
      res_in       = res_ff;
      term_in      = term_ff;
      d_in         = d_ff;
      prod_in      = prod_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_ch.payload.operation == OP_EVAL) begin
                  point_in = req_ch.payload.query_point;
                  k_in     = DATA_W'(1) <<< FRAC_BITS;
                  res_in   = '0;
                  esat_in  = tsat_ff;
                  j_in     = '0;
                  stat_in  = !built_ff ? STATUS_NOT_BUILT : STATUS_COINCIDENT;
               end else if (load_ok) begin
                  abs_in[load_node] = req_ch.payload.node_x;
                  nd_in[ENTRY_W'(REPEAT * 32'(load_node))]     = req_ch.payload.node_value;
                  nd_in[ENTRY_W'(REPEAT * 32'(load_node) + 1)] = req_ch.payload.node_slope;
                  nd_in[ENTRY_W'(REPEAT * 32'(load_node) + 2)] =
                     req_ch.payload.node_curvature;
                  mask_in = mask_next;
               end
            end
         end
         ST_INIT: begin
            for (int e = 0; e < ENTRY_COUNT; e++) begin
               col_in[e] = nd_ff[ENTRY_W'(REPEAT * 32'(node_of(ENTRY_W'(e))))];
            end
            prev_in = nd_ff[0];
            err_in  = 1'b0;
            bsat_in = 1'b0;
            i_in    = COL_W'(2);
            j_in    = ENTRY_W'(1);
         end
         ST_COL: begin
            prev_in = col_rd;
            j_in    = ENTRY_W'(i_ff - COL_W'(1));
         end
         ST_READ: begin
            old_in = col_rd;
            xa_in  = abs_rd;
            if (take_slope) begin
               new_in = nd_rd;
            end else if (take_half) begin
               new_in = half_toward_zero(nd_rd);
            end
         end
         ST_SUB: begin
            bsat_in = bsat_ff | diff.sat;
            if (den == '0) begin
               err_in = 1'b1;
               new_in = '0;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               new_in  = div_res.quo;
               bsat_in = bsat_ff | div_res.sat;
            end
         end
         ST_WRITE: begin
            col_in[j_ff] = new_ff;
            prev_in      = old_ff;
            if (32'(j_ff) == ENTRY_COUNT - 1) begin
               if (32'(i_ff) == ENTRY_COUNT) begin
                  built_in = 1'b1;
                  tsat_in  = bsat_ff;
               end else begin
                  i_in = i_ff + COL_W'(1);
               end
            end else begin
               j_in = j_ff + ENTRY_W'(1);
            end
         end
         ST_MUL_C, ST_MUL_D: begin
            prod_in = mul_p;
         end
         ST_TERM: begin
            term_in = scaled.val;
            esat_in = esat_ff | scaled.sat;
         end
         ST_ACC: begin
            res_in  = diff.val;
            stat_in = (esat_ff || diff.sat) ? STATUS_SATURATED : STATUS_OK;
            esat_in = esat_ff | diff.sat;
         end
         ST_DIFF: begin
            d_in    = diff.val;
            esat_in = esat_ff | diff.sat;
         end
         ST_SCALE: begin
            k_in    = scaled.val;
            esat_in = esat_ff | scaled.sat;
            j_in    = j_ff + ENTRY_W'(1);
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = res_ff;
               rsp_in.status       = stat_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mask_ff      <= '0;
         built_ff     <= 1'b0;
         err_ff       <= 1'b0;
         tsat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mask_ff      <= mask_in;
         built_ff     <= built_in;
         err_ff       <= err_in;
         tsat_ff      <= tsat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      abs_ff   <= abs_in;
      nd_ff    <= nd_in;
      col_ff   <= col_in;
      bsat_ff  <= bsat_in;
      esat_ff  <= esat_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      prev_ff  <= prev_in;
      old_ff   <= old_in;
      xa_ff    <= xa_in;
      new_ff   <= new_in;
      point_ff <= point_in;
      k_ff     <= k_in;
      res_ff   <= res_in;
      term_ff  <= term_in;
      d_ff     <= d_in;
      prod_ff  <= prod_in;
      stat_ff  <= stat_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ===== sv/hddi_checker.sv =====
// ----------------------------------------------------------------------------
// hddi_checker: port-level assertions
// Checks the interpolator's channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module hddi_checker import hddi_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_result_value,
   input logic [1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value)
                                  && $stable(rsp_status))
      else $error("A stalled response item changed.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_NOT_BUILT || rsp_status == STATUS_COINCIDENT)
      |-> rsp_result_value == '0)
      else $error("An error response item carries a nonzero value.");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_EVAL |=> !req_ready)
      else $error("The block took a new item right after an evaluate.");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("A response item appeared right after reset.");

endmodule

bind hermite_divided_difference_interp hddi_checker u_hddi_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_operation    (req_ch.payload.operation),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_result_value (rsp_ch.payload.result_value),
   .rsp_status       (rsp_ch.payload.status)
);
